[rtl/core/ckgs_pkg.sv]
// Shared types and constants of the crank key/gap sync decoder.
// Used by the datapath, the divider, the controller and the top level.
package ckgs_pkg;

    localparam int IV_W        = 16;
    localparam int POSITIONS   = 8;
    localparam int RPM_SAMPLES = 16;
    localparam int CNT_W       = $clog2(RPM_SAMPLES);
    localparam int SUM_W       = IV_W + CNT_W;
    localparam int POS_W       = 4;
    localparam int DIV_W       = 28;
    localparam int PROD_W      = IV_W + 7;
    localparam int STEP_W      = $clog2(DIV_W);

    localparam logic [DIV_W-1:0] RPM_CONST   = 28'd172800000;
    localparam logic [6:0]       RATIO_SCALE = 7'd100;

    localparam logic [POS_W-1:0] POS_A2    = 4'd1;
    localparam logic [POS_W-1:0] POS_B1    = 4'd2;
    localparam logic [POS_W-1:0] POS_UNDEF = 4'd8;

    // Item commands
    localparam logic [1:0] CMD_CRANK = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_CAM   = 2'd2;

    // Decoder modes
    localparam logic [1:0] MODE_INIT = 2'd0;
    localparam logic [1:0] MODE_KEY  = 2'd1;
    localparam logic [1:0] MODE_GAP  = 2'd2;
    localparam logic [1:0] MODE_SYNC = 2'd3;

    // Cylinder phase codes
    localparam logic [1:0] PHASE_UNDEF = 2'd0;
    localparam logic [1:0] PHASE_CYL1  = 2'd1;
    localparam logic [1:0] PHASE_CYL2  = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_RATIO_MIN  = 3'd0;
    localparam logic [2:0] REG_RATIO_MAX  = 3'd1;
    localparam logic [2:0] REG_TIMEOUT    = 3'd2;
    localparam logic [2:0] REG_CAM_OPEN   = 3'd3;
    localparam logic [2:0] REG_CAM_CLOSE  = 3'd4;
    localparam logic [2:0] REG_KEY_RISING = 3'd5;

    typedef struct packed {
        logic [9:0] ratio_min;
        logic [9:0] ratio_max;
        logic [7:0] timeout;
        logic [2:0] cam_open;
        logic [2:0] cam_close;
        logic       key_rising;
    } ckgs_cfg_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_ratio;
        logic cap_rpm;
        logic cap_ratio;
        logic commit;
    } ckgs_cmd_t;

    typedef struct packed {
        logic need_rpm;
        logic need_ratio;
        logic div_done;
    } ckgs_stat_t;

endpackage

[rtl/core/crank_key_gap_sync_decoder_core.sv]
// Top level of the crank key/gap sync decoder: APB registers and instances.
// Depends on ckgs_pkg, ckgs_dp (with ckgs_div) and ckgs_ctrl.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  in       | in_valid / in_stall        | command, interval
//  out      | out_valid / out_stall      | sync_state .. position_event (9 fields)
//  apb      | psel, penable, pready      | paddr, pwrite, pwdata, prdata
//
// One item at a time: most items need no division, others need one 28-bit division
// (rpm every sixteenth synced edge, or the key/gap ratio) or both, run one after the
// other on the shared bit-serial divider.
// The next item is taken once the result is committed to the output register.
// A stalled output holds the result; a finished item waits in commit meanwhile.
// rst_n clears the decoder to init, the output to empty, registers to defaults.
module crank_key_gap_sync_decoder_core
    import ckgs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       command,
    input  logic [IV_W-1:0]  interval,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       sync_state,
    output logic [POS_W-1:0] position,
    output logic [1:0]       engine_phase,
    output logic [DIV_W-1:0] engine_speed,
    output logic             watch_rising_edge,
    output logic             cam_window_open,
    output logic             sync_lost,
    output logic             phase_lost,
    output logic             position_event,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    ckgs_cfg_t  cfg_reg;
    ckgs_cmd_t  cmd;
    ckgs_stat_t stat;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ratio_min  <= 10'd0;
            cfg_reg.ratio_max  <= 10'd1023;
            cfg_reg.timeout    <= 8'd88;
            cfg_reg.cam_open   <= 3'd0;
            cfg_reg.cam_close  <= 3'd4;
            cfg_reg.key_rising <= 1'b1;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_RATIO_MIN:  cfg_reg.ratio_min  <= pwdata[9:0];
                REG_RATIO_MAX:  cfg_reg.ratio_max  <= pwdata[9:0];
                REG_TIMEOUT:    cfg_reg.timeout    <= pwdata[7:0];
                REG_CAM_OPEN:   cfg_reg.cam_open   <= pwdata[2:0];
                REG_CAM_CLOSE:  cfg_reg.cam_close  <= pwdata[2:0];
                REG_KEY_RISING: cfg_reg.key_rising <= pwdata[0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_RATIO_MIN:  prdata = 32'(cfg_reg.ratio_min);
            REG_RATIO_MAX:  prdata = 32'(cfg_reg.ratio_max);
            REG_TIMEOUT:    prdata = 32'(cfg_reg.timeout);
            REG_CAM_OPEN:   prdata = 32'(cfg_reg.cam_open);
            REG_CAM_CLOSE:  prdata = 32'(cfg_reg.cam_close);
            REG_KEY_RISING: prdata = 32'(cfg_reg.key_rising);
            default:        prdata = '0;
        endcase
    end

    ckgs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ckgs_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .cmd               (cmd),
        .stat              (stat),
        .command           (command),
        .interval          (interval),
        .sync_state        (sync_state),
        .position          (position),
        .engine_phase      (engine_phase),
        .engine_speed      (engine_speed),
        .watch_rising_edge (watch_rising_edge),
        .cam_window_open   (cam_window_open),
        .sync_lost         (sync_lost),
        .phase_lost        (phase_lost),
        .position_event    (position_event)
    );

endmodule

[rtl/core/ckgs_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on ckgs_pkg for operand widths.
module ckgs_div
    import ckgs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [SUM_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic             done
);

    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SUM_W:0]    rem_shift;
    logic              fits;

    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DIV_W-2:0], fits};
            rem_next  = fits ? SUM_W'(rem_shift - {1'b0, dvs_reg}) : rem_shift[SUM_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    a_done_single : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

    a_done_after_busy : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_start_idle : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

[rtl/core/ckgs_dp.sv]
// Datapath: decoder state, rpm accumulator, ratio and rpm division.
// Depends on ckgs_pkg and ckgs_div; driven by ckgs_ctrl commands.
module ckgs_dp
    import ckgs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ckgs_cfg_t        cfg,
    input  ckgs_cmd_t        cmd,
    output ckgs_stat_t       stat,
    input  logic [1:0]       command,
    input  logic [IV_W-1:0]  interval,
    output logic [1:0]       sync_state,
    output logic [POS_W-1:0] position,
    output logic [1:0]       engine_phase,
    output logic [DIV_W-1:0] engine_speed,
    output logic             watch_rising_edge,
    output logic             cam_window_open,
    output logic             sync_lost,
    output logic             phase_lost,
    output logic             position_event
);

    logic [1:0]       cmd_reg;
    logic [IV_W-1:0]  iv_reg;
    logic [DIV_W-1:0] rpm_q_reg;
    logic             ratio_pass_reg;

    logic [1:0]       mode_reg, mode_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       phase_reg, phase_next;
    logic [IV_W-1:0]  key_reg, key_next;
    logic [IV_W-1:0]  gap_reg, gap_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rpm_reg, rpm_next;
    logic [7:0]       idle_reg, idle_next;
    logic             edge_reg, edge_next;
    logic             win_reg, win_next;
    logic             lost_sync_reg, lost_sync_next;
    logic             lost_phase_reg, lost_phase_next;
    logic             pos_event_reg, pos_event_next;

    logic [SUM_W-1:0]  sum_add;
    logic [POS_W-1:0]  pos_adv;
    logic              last_sample;
    logic              ratio_ok;
    logic [PROD_W-1:0] key_scaled;
    logic [DIV_W-1:0]  div_dividend;
    logic [SUM_W-1:0]  div_divisor;
    logic [DIV_W-1:0]  div_quotient;
    logic              div_done;

    assign sum_add     = sum_reg + SUM_W'(iv_reg);
    assign pos_adv     = (pos_reg >= POS_W'(POSITIONS - 1)) ? '0 : pos_reg + 1'b1;
    assign last_sample = cnt_reg == CNT_W'(RPM_SAMPLES - 1);
    assign ratio_ok    = (iv_reg != '0) && ratio_pass_reg;
    assign key_scaled  = PROD_W'(key_reg) * PROD_W'(RATIO_SCALE);

    assign div_dividend = cmd.div_ratio ? DIV_W'(key_scaled) : RPM_CONST;
    assign div_divisor  = cmd.div_ratio ? SUM_W'(iv_reg) : sum_add;

    ckgs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // A zero gap or zero sum skips its division: the commit handles those directly.
    always_comb
    begin
        stat.div_done   = div_done;
        stat.need_rpm   = (cmd_reg == CMD_CRANK) && (mode_reg == MODE_SYNC)
                          && last_sample && (sum_add != '0);
        stat.need_ratio = (cmd_reg == CMD_CRANK) && (iv_reg != '0)
                          && ((mode_reg == MODE_GAP)
                              || ((mode_reg == MODE_SYNC) && (pos_adv == POS_B1)));
    end

    always_comb
    begin
        mode_next       = mode_reg;
        pos_next        = pos_reg;
        phase_next      = phase_reg;
        key_next        = key_reg;
        gap_next        = gap_reg;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        rpm_next        = rpm_reg;
        idle_next       = idle_reg;
        edge_next       = edge_reg;
        win_next        = win_reg;
        lost_sync_next  = 1'b0;
        lost_phase_next = 1'b0;
        pos_event_next  = 1'b0;

        case (cmd_reg)
            CMD_CRANK:
            begin
                idle_next = '0;
                case (mode_reg)
                    MODE_INIT:
                    begin
                        edge_next  = ~cfg.key_rising;
                        mode_next  = MODE_KEY;
                        pos_next   = POS_UNDEF;
                        phase_next = PHASE_UNDEF;
                        sum_next   = '0;
                        cnt_next   = '0;
                    end
                    MODE_KEY:
                    begin
                        key_next  = iv_reg;
                        edge_next = cfg.key_rising;
                        mode_next = MODE_GAP;
                        pos_next  = POS_UNDEF;
                    end
                    MODE_GAP:
                    begin
                        gap_next  = iv_reg;
                        edge_next = ~cfg.key_rising;
                        if (ratio_ok)
                        begin
                            mode_next  = MODE_SYNC;
                            pos_next   = POS_B1;
                            phase_next = PHASE_UNDEF;
                            sum_next   = '0;
                            cnt_next   = '0;
                            rpm_next   = '0;
                        end
                        else
                        begin
                            mode_next = MODE_KEY;
                            pos_next  = POS_UNDEF;
                        end
                    end
                    default:
                    begin
                        pos_next  = pos_adv;
                        edge_next = ~edge_reg;
                        if (last_sample)
                        begin
                            rpm_next = (sum_add == '0) ? RPM_CONST : rpm_q_reg;
                            sum_next = '0;
                            cnt_next = '0;
                        end
                        else
                        begin
                            sum_next = sum_add;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        if (pos_adv == POS_A2)
                        begin
                            key_next = iv_reg;
                        end
                        else if (pos_adv == POS_B1)
                        begin
                            gap_next = iv_reg;
                            if (!ratio_ok)
                            begin
                                pos_next       = POS_UNDEF;
                                mode_next      = MODE_KEY;
                                edge_next      = cfg.key_rising;
                                phase_next     = PHASE_UNDEF;
                                win_next       = 1'b0;
                                lost_sync_next = 1'b1;
                            end
                        end
                        // Opening wins when open and close name the same position
                        if (pos_next == {1'b0, cfg.cam_open})
                        begin
                            win_next = 1'b1;
                        end
                        else if (pos_next == {1'b0, cfg.cam_close})
                        begin
                            win_next = 1'b0;
                            if (phase_next == PHASE_CYL1)
                            begin
                                phase_next = PHASE_CYL2;
                            end
                            else if (phase_next == PHASE_CYL2)
                            begin
                                phase_next      = PHASE_UNDEF;
                                lost_phase_next = 1'b1;
                            end
                        end
                        pos_event_next = 1'b1;
                    end
                endcase
            end
            CMD_TICK:
            begin
                // Timer stands still in init: drop the tick
                if (mode_reg != MODE_INIT)
                begin
                    if (idle_reg >= cfg.timeout)
                    begin
                        mode_next      = MODE_INIT;
                        pos_next       = POS_UNDEF;
                        sum_next       = '0;
                        cnt_next       = '0;
                        rpm_next       = '0;
                        pos_event_next = 1'b1;
                        edge_next      = cfg.key_rising;
                        win_next       = 1'b0;
                        phase_next     = PHASE_UNDEF;
                    end
                    else
                    begin
                        idle_next = idle_reg + 1'b1;
                    end
                end
            end
            CMD_CAM:
            begin
                if (win_reg)
                begin
                    if ((phase_reg == PHASE_CYL2) || (phase_reg == PHASE_UNDEF))
                    begin
                        phase_next = PHASE_CYL1;
                    end
                    else if (phase_reg == PHASE_CYL1)
                    begin
                        phase_next      = PHASE_UNDEF;
                        lost_phase_next = 1'b1;
                    end
                    win_next = 1'b0;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_INIT;
            pos_reg        <= POS_UNDEF;
            phase_reg      <= PHASE_UNDEF;
            key_reg        <= '0;
            gap_reg        <= '0;
            sum_reg        <= '0;
            cnt_reg        <= '0;
            rpm_reg        <= '0;
            idle_reg       <= '0;
            edge_reg       <= 1'b1;
            win_reg        <= 1'b0;
            lost_sync_reg  <= 1'b0;
            lost_phase_reg <= 1'b0;
            pos_event_reg  <= 1'b0;
        end
        else if (cmd.commit)
        begin
            mode_reg       <= mode_next;
            pos_reg        <= pos_next;
            phase_reg      <= phase_next;
            key_reg        <= key_next;
            gap_reg        <= gap_next;
            sum_reg        <= sum_next;
            cnt_reg        <= cnt_next;
            rpm_reg        <= rpm_next;
            idle_reg       <= idle_next;
            edge_reg       <= edge_next;
            win_reg        <= win_next;
            lost_sync_reg  <= lost_sync_next;
            lost_phase_reg <= lost_phase_next;
            pos_event_reg  <= pos_event_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= command;
            iv_reg  <= interval;
        end
        if (cmd.cap_rpm)
        begin
            rpm_q_reg <= div_quotient;
        end
        if (cmd.load)
        begin
            ratio_pass_reg <= 1'b0;
        end
        else if (cmd.cap_ratio)
        begin
            ratio_pass_reg <= (div_quotient >= DIV_W'(cfg.ratio_min))
                              && (div_quotient <= DIV_W'(cfg.ratio_max));
        end
    end

    assign sync_state        = mode_reg;
    assign position          = pos_reg;
    assign engine_phase      = phase_reg;
    assign engine_speed      = rpm_reg;
    assign watch_rising_edge = edge_reg;
    assign cam_window_open   = win_reg;
    assign sync_lost         = lost_sync_reg;
    assign phase_lost        = lost_phase_reg;
    assign position_event    = pos_event_reg;

    a_pos_undef : assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_SYNC) |-> (pos_reg == POS_UNDEF))
        else $error("defined position outside sync");

    a_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_SYNC) |-> (pos_reg < POS_W'(POSITIONS)))
        else $error("position out of range while synced");

    a_lost_leaves_sync : assert property (@(posedge clk) disable iff (!rst_n)
        lost_sync_reg |-> (mode_reg == MODE_KEY))
        else $error("sync loss without return to key search");

endmodule

[rtl/core/ckgs_ctrl.sv]
// Controller: sequences item load, divisions and commit; owns both handshakes.
// Depends on ckgs_pkg; drives ckgs_dp through command and status structs.
module ckgs_ctrl
    import ckgs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  ckgs_stat_t stat,
    output ckgs_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_CHECK     = 5'b00010,
        ST_RPM_DIV   = 5'b00100,
        ST_RATIO_DIV = 5'b01000,
        ST_COMMIT    = 5'b10000
    } ckgs_state_t;

    ckgs_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = state_reg != ST_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.need_rpm)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_RPM_DIV;
                end
                else if (stat.need_ratio)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_ratio = 1'b1;
                    state_next    = ST_RATIO_DIV;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_RPM_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.cap_rpm = 1'b1;
                    if (stat.need_ratio)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_ratio = 1'b1;
                        state_next    = ST_RATIO_DIV;
                    end
                    else
                    begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_RATIO_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.cap_ratio = 1'b1;
                    state_next    = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                // Hold the result until the previous transfer has gone out
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_commit_free : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> out_free)
        else $error("commit over an untaken result");

    a_load_check : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_CHECK))
        else $error("accepted item not checked next cycle");

    a_commit_valid : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit did not raise out_valid");

endmodule
